/* hdl/pswl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswl_pkg: shared definitions of the sliding window limiter
// Field widths, register indexes, parameter defaults and the sequencer states.
// ----------------------------------------------------------------------------
package pswl_pkg;

  localparam int USER_SLOTS_DEFAULT = 256;
  localparam int RING_DEPTH_DEFAULT = 16;

  localparam int USER_W      = 8;
  localparam int TIME_W      = 32;
  localparam int LIMIT_W     = 5;
  localparam int WINDOW_W    = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_REQUEST_LIMIT = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = CFG_INDEX_W'(1);

  typedef struct packed {
    logic [LIMIT_W-1:0]  request_limit;
    logic [WINDOW_W-1:0] window_length;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_META,
    ST_CHECK,
    ST_DECIDE,
    ST_REJECT
  } state_t;

endpackage

/* hdl/pswl_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswl_if: request and result channels
// Valid/ready channels; an item moves on a clock edge with both high.
// ----------------------------------------------------------------------------
interface pswl_req_if import pswl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [USER_W-1:0] user_index;
  logic [TIME_W-1:0] request_time;

  modport source (output valid, output user_index, output request_time, input ready);
  modport sink   (input valid, input user_index, input request_time, output ready);
endinterface

interface pswl_res_if ();
  logic valid;
  logic ready;
  logic allowed;

  modport source (output valid, output allowed, input ready);
  modport sink   (input valid, input allowed, output ready);
endinterface

/* hdl/pswl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswl_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pswl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/pswl_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswl_seq: request sequencer
// Reads a user's ring state, pops expired stamps one a cycle, then decides
// and writes the ring state back, and the stamp if the request is allowed.
// ----------------------------------------------------------------------------
module pswl_seq import pswl_pkg::*; #(
  parameter int USER_SLOTS = USER_SLOTS_DEFAULT,
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT,
  localparam int UW  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1,
  localparam int RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int CW  = $clog2(RING_DEPTH + 1),
  localparam int MW  = RW + CW,
  localparam int SD  = USER_SLOTS * RING_DEPTH,
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  pswl_req_if.sink          req,
  pswl_res_if.source        res,
  output logic              meta_we,
  output logic [UW-1:0]     meta_waddr,
  output logic [MW-1:0]     meta_wdata,
  output logic              meta_re,
  output logic [UW-1:0]     meta_raddr,
  input  logic [MW-1:0]     meta_rdata,
  output logic              stamp_we,
  output logic [SAW-1:0]    stamp_waddr,
  output logic [TIME_W-1:0] stamp_wdata,
  output logic              stamp_re,
  output logic [SAW-1:0]    stamp_raddr,
  input  logic [TIME_W-1:0] stamp_rdata
);

  localparam int SW = RW + 2;

  state_t state, state_next;

  logic [UW-1:0]     clr_addr;
  logic [UW-1:0]     user;
  logic [SAW-1:0]    base;
  logic [TIME_W-1:0] now;
  logic [TIME_W:0]   now_p1;
  logic [RW-1:0]     head;
  logic [CW-1:0]     count;
  logic              out_valid;
  logic              out_allowed;

  logic [RW-1:0] meta_head_rd;
  logic [CW-1:0] meta_count_rd;
  logic [RW-1:0] head_inc;
  logic [SW-1:0] tail_sum;
  logic [RW-1:0] tail;
  logic          in_range;
  logic          expired;
  logic          grant;
  logic          out_free;
  logic          out_load;
  logic          out_bit;

  assign meta_head_rd  = meta_rdata[MW-1:CW];
  assign meta_count_rd = meta_rdata[CW-1:0];

  assign head_inc = (head == RW'(RING_DEPTH - 1)) ? '0 : head + RW'(1);
  assign tail_sum = SW'(head) + SW'(count);
  assign tail     = (tail_sum >= SW'(RING_DEPTH)) ? RW'(tail_sum - SW'(RING_DEPTH))
                                                  : RW'(tail_sum);

  assign in_range = 32'(req.user_index) < USER_SLOTS;

  // The sum is taken one bit wider than a stamp so that it cannot wrap.
  assign expired = ({1'b0, stamp_rdata} + (TIME_W + 1)'(cfg.window_length)) < now_p1;

  // A limit above the ring depth behaves as the ring depth.
  assign grant = (16'(count) < 16'(cfg.request_limit)) && (32'(count) < RING_DEPTH);

  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Every access to one user's entries is ordered by the sequencer: the
  // write-back in the decide step lands before the next request's read is
  // issued, so no forwarding path is needed.
  always_comb begin
    state_next  = state;
    req.ready   = 1'b0;
    meta_we     = 1'b0;
    meta_waddr  = user;
    meta_wdata  = {head, count + CW'(grant)};
    meta_re     = 1'b0;
    meta_raddr  = UW'(req.user_index);
    stamp_we    = 1'b0;
    stamp_waddr = base + SAW'(tail);
    stamp_wdata = now;
    stamp_re    = 1'b0;
    stamp_raddr = base + SAW'(meta_head_rd);
    out_load    = 1'b0;
    out_bit     = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_addr;
        meta_wdata = '0;
        if (clr_addr == UW'(USER_SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          if (in_range) begin
            meta_re    = 1'b1;
            state_next = ST_META;
          end else begin
            state_next = ST_REJECT;
          end
        end
      end
      ST_META: begin
        if (meta_count_rd != '0) begin
          stamp_re   = 1'b1;
          state_next = ST_CHECK;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_CHECK: begin
        stamp_raddr = base + SAW'(head_inc);
        if (expired && count != CW'(1)) begin
          stamp_re = 1'b1;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_bit    = grant;
          meta_we    = 1'b1;
          stamp_we   = grant;
          state_next = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (state == ST_CLEAR) begin
      clr_addr <= clr_addr + UW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          user   <= UW'(req.user_index);
          base   <= SAW'(SAW'(req.user_index) * SAW'(RING_DEPTH));
          now    <= req.request_time;
          now_p1 <= {1'b0, req.request_time} + (TIME_W + 1)'(1);
        end
      end
      ST_META: begin
        head  <= meta_head_rd;
        count <= meta_count_rd;
      end
      ST_CHECK: begin
        if (expired) begin
          head  <= head_inc;
          count <= count - CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_allowed <= out_bit;
    end
  end

  assign res.valid   = out_valid;
  assign res.allowed = out_allowed;

endmodule

/* hdl/per_user_sliding_window_limiter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_user_sliding_window_limiter_core: per-user sliding window rate limiter
// Keeps a ring of allowed request stamps per user and answers each request.
// ----------------------------------------------------------------------------
// Each request is answered with one result item. Every stored stamp examined
// adds to the time a request takes, because the stamps of a user are read
// one at a time from the stamp memory's single read port; every stamp is
// dropped at most once. A new request is taken while the previous result
// still waits at the output. After reset the per-user ring state memory is
// cleared, one user a cycle; no request is taken during that pass, but
// register writes are. Registers: index 0 is the request limit, index 1 the
// window length; other indexes are ignored. Write them only while the block
// is idle.
// ----------------------------------------------------------------------------
module per_user_sliding_window_limiter_core import pswl_pkg::*; #(
  parameter int USER_SLOTS = USER_SLOTS_DEFAULT,
  parameter int RING_DEPTH = RING_DEPTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pswl_req_if.sink               req,
  pswl_res_if.source             res
);

  localparam int UW  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;
  localparam int RW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW  = $clog2(RING_DEPTH + 1);
  localparam int MW  = RW + CW;
  localparam int SD  = USER_SLOTS * RING_DEPTH;
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;

  cfg_t cfg;

  logic              meta_we;
  logic [UW-1:0]     meta_waddr;
  logic [MW-1:0]     meta_wdata;
  logic              meta_re;
  logic [UW-1:0]     meta_raddr;
  logic [MW-1:0]     meta_rdata;
  logic              stamp_we;
  logic [SAW-1:0]    stamp_waddr;
  logic [TIME_W-1:0] stamp_wdata;
  logic              stamp_re;
  logic [SAW-1:0]    stamp_raddr;
  logic [TIME_W-1:0] stamp_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_limit <= LIMIT_W'(1);
      cfg.window_length <= WINDOW_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_REQUEST_LIMIT: cfg.request_limit <= cfg_data[LIMIT_W-1:0];
        REG_WINDOW_LENGTH: cfg.window_length <= cfg_data[WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pswl_seq #(
    .USER_SLOTS (USER_SLOTS),
    .RING_DEPTH (RING_DEPTH)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .req         (req),
    .res         (res),
    .meta_we     (meta_we),
    .meta_waddr  (meta_waddr),
    .meta_wdata  (meta_wdata),
    .meta_re     (meta_re),
    .meta_raddr  (meta_raddr),
    .meta_rdata  (meta_rdata),
    .stamp_we    (stamp_we),
    .stamp_waddr (stamp_waddr),
    .stamp_wdata (stamp_wdata),
    .stamp_re    (stamp_re),
    .stamp_raddr (stamp_raddr),
    .stamp_rdata (stamp_rdata)
  );

  // Oldest ring position and stamp count of every user.
  pswl_ram #(
    .WIDTH (MW),
    .DEPTH (USER_SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .re    (meta_re),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  // Stamp rings, RING_DEPTH entries per user.
  pswl_ram #(
    .WIDTH (TIME_W),
    .DEPTH (SD)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_waddr),
    .wdata (stamp_wdata),
    .re    (stamp_re),
    .raddr (stamp_raddr),
    .rdata (stamp_rdata)
  );

endmodule

/* hdl/pswl_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pswl_checker: port-level checks of the limiter
// Watches the channels of the top level and tracks items in flight.
// ----------------------------------------------------------------------------
module pswl_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_allowed
);

  logic [1:0] pending;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_take && !out_take) begin
      pending <= pending + 2'd1;
    end else if (out_take && !in_take) begin
      pending <= pending - 2'd1;
    end
  end

  // A result is only ever offered for an item that was taken.
  a_no_invented_result: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result offered with no item in flight");

  // At most one item in work and one result waiting.
  a_bounded_in_flight: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many items in flight");

  // The state clearing pass follows reset; no item is taken at once.
  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !in_ready)
    else $error("item taken during clearing pass");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_allowed))
    else $error("stalled result changed");

endmodule

bind per_user_sliding_window_limiter_core pswl_checker u_pswl_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (req.valid),
  .in_ready    (req.ready),
  .out_valid   (res.valid),
  .out_ready   (res.ready),
  .out_allowed (res.allowed)
);
